### src/pgm_pkg.sv
package pgm_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam logic [16:0] ACC_MAX = 17'd131071;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_5 = 8'h35;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MAGIC  = 2'd1,
    ERR_FIELD  = 2'd2,
    ERR_RANGE  = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_MAGIC_P, PH_MAGIC_D, PH_MAGIC_S, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
    PH_PIX_ASCII, PH_PIX_BYTE, PH_PIX_HI, PH_PIX_LO, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_EMIT, ST_HALT
  } ctl_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [16:0] pixel_value;
    logic [23:0] dest_index;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  error_code;
    logic        last_pixel;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic parse;     // run one byte through the parser
    logic mul_go;    // compute destination index
    logic div_start; // load divider
    logic div_step;  // one divider bit
    logic load_out;  // latch result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic want_pixel; // parse produced a pixel
    logic want_result; // parse produced a header/error
    logic div_done;
    logic halted;
  } stat_t;

  function automatic logic is_ws(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

### src/pgm_stream_parser.sv
// PGM stream parser.
// in channel: one file byte per item (in_byte, end_of_file) on in_valid/in_ready.
// out channel: result items (pixel, header or error) on out_valid/out_ready.
// cfg channel: cfg_valid/cfg_ready writes the index order bit (1 row-first,
//   0 column-first, reset 1); write it only while no item is in flight.
// Handshake: a byte with no result is taken without holding the input.
//   A byte that ends the header or raises an error holds the input until
//   its item is loaded into the output register.
// A byte that completes a pixel holds the input through the index
//   multiply step, 16 restoring divider steps for v*65536/maxval (values at
//   or above maxval saturate to 1.0), and the load into the output register.
// The parser holds one item at a time; in_ready drops while a result is
// being computed or is waiting for a full output register to free.
// A stalled receiver holds the output register; the next result waits in
// the datapath with in_ready low.
// After an error or the final pixel all further items are accepted and
// dropped until reset. Reset (rst, synchronous) returns to magic parsing.
module pgm_stream_parser import pgm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  cmd_t      cmd;
  stat_t     stat;
  out_item_t res;
  logic      row_first;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) row_first <= 1'b1;
    else if (cfg_valid && cfg_ready) row_first <= cfg_data;
  end

  pgm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_full(out_valid && !out_ready),
    .stat, .cmd
  );

  pgm_dpath #(.MAX_DIM(MAX_DIM)) u_dpath (
    .clk, .rst, .item(in_data), .row_first, .cmd, .stat, .res
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_data <= res;
  end

endmodule

### src/pgm_ctrl.sv
module pgm_ctrl import pgm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  out_full,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (stat.want_pixel) state_next = ST_MUL;
          else if (stat.want_result) state_next = ST_EMIT;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_EMIT;
      ST_EMIT: if (!out_full) state_next = stat.halted ? ST_HALT : ST_IDLE;
      ST_HALT: state_next = ST_HALT;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.parse = in_valid;
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        cmd.div_start = 1'b1;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_EMIT: cmd.load_out = !out_full;
      ST_HALT: in_ready = 1'b1;
      default: ;
    endcase
  end

endmodule

### src/pgm_dpath.sv
module pgm_dpath import pgm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  logic      row_first,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t res
);

  phase_t      phase;
  logic [7:0]  magic_char, high_byte;
  logic        in_comment, digits_seen, halted;
  logic [16:0] acc;
  logic [12:0] width_reg, height_reg, row_count, col_count;
  logic [15:0] maxval_reg;
  logic [24:0] pixels_done;

  // pending result of the parsed byte
  out_item_t   pend;
  out_item_t   pend_n;
  logic [15:0] pix_raw;
  logic [12:0] prow, pcol;

  // parse combinational
  phase_t      ph_n;
  logic [7:0]  mc_n, hb_n;
  logic        ic_n, ds_n, hl_n;
  logic [16:0] acc_n;
  logic [12:0] w_n, h_n, r_n, c_n;
  logic [15:0] mv_n;
  logic [24:0] pd_n;
  logic        emit_px, emit_rs;
  logic [15:0] px_v;
  kind_t       rk;
  err_t        ec;
  logic        last_n;

  logic [20:0] dig_mul;
  logic [7:0]  b;
  logic [16:0] num;
  logic        dim_ok;
  logic [25:0] total;

  // divider: q = (v<<16)/maxval, restoring. A value at or above maxval
  // saturates at 1.0, so only the 16 fraction bits are computed.
  logic [16:0] rem_r;
  logic [15:0] quo;
  logic        sat;
  logic [4:0]  div_cnt;
  logic [16:0] trial_rem;
  logic [17:0] trial;
  logic [23:0] idx_r;

  assign b = item.in_byte;
  assign dig_mul = {4'd0, acc} * 21'd10 + {17'd0, b[3:0]};
  assign num = acc;
  assign dim_ok = (num >= 17'd1) && (num <= 17'(MAX_DIM));
  assign total = 26'(width_reg) * 26'(height_reg);

  always_comb begin
    ph_n = phase; mc_n = magic_char; hb_n = high_byte; ic_n = in_comment;
    ds_n = digits_seen; hl_n = halted;
    acc_n = acc; w_n = width_reg; h_n = height_reg; r_n = row_count;
    c_n = col_count; mv_n = maxval_reg; pd_n = pixels_done;
    emit_px = 1'b0; emit_rs = 1'b0; px_v = '0; rk = KIND_HEADER; ec = ERR_NONE;
    last_n = 1'b0;
    if (!halted && phase != PH_DONE) begin
      if (in_comment) begin
        if (b == CH_LF) ic_n = 1'b0;
      end else begin
        case (phase)
          PH_MAGIC_P:
            if (b == CH_P) ph_n = PH_MAGIC_D;
            else if (!is_ws(b)) begin
              emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_MAGIC;
            end
          PH_MAGIC_D:
            if (b == CH_2 || b == CH_5) begin mc_n = b; ph_n = PH_MAGIC_S; end
            else begin emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_MAGIC; end
          PH_MAGIC_S:
            if (is_ws(b)) ph_n = PH_WIDTH;
            else begin emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_MAGIC; end
          PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIX_ASCII: begin
            if (is_digit(b)) begin
              acc_n = (dig_mul > 21'(ACC_MAX)) ? ACC_MAX : dig_mul[16:0];
              ds_n = 1'b1;
            end else if (phase == PH_HEIGHT && (is_ws(b) || b == CH_HASH)
                         && digits_seen) begin
              acc_n = '0; ds_n = 1'b0;
              if (!dim_ok) begin emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_RANGE; end
              else begin
                h_n = num[12:0]; ph_n = PH_MAXVAL;
                if (b == CH_HASH) ic_n = 1'b1;
              end
            end else if (phase == PH_HEIGHT) begin
              if (!is_ws(b)) begin emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_FIELD; end
            end else if (is_ws(b)) begin
              if (digits_seen) begin
                acc_n = '0; ds_n = 1'b0;
                case (phase)
                  PH_WIDTH:
                    if (!dim_ok) begin
                      emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_RANGE;
                    end else begin w_n = num[12:0]; ph_n = PH_HEIGHT; end
                  PH_MAXVAL:
                    if (num < 17'd1 || num > 17'd65535) begin
                      emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_RANGE;
                    end else begin
                      mv_n = num[15:0];
                      r_n = '0; c_n = '0; pd_n = '0;
                      emit_rs = 1'b1; rk = KIND_HEADER;
                      if (magic_char != CH_5) ph_n = PH_PIX_ASCII;
                      else ph_n = (num >= 17'd256) ? PH_PIX_HI : PH_PIX_BYTE;
                    end
                  default: begin emit_px = 1'b1; px_v = num[15:0]; end
                endcase
              end
            end else if (b == CH_HASH && !digits_seen && phase != PH_PIX_ASCII)
              ic_n = 1'b1;
            else begin emit_rs = 1'b1; rk = KIND_ERROR; ec = ERR_FIELD; end
          end
          PH_PIX_BYTE: begin emit_px = 1'b1; px_v = {8'd0, b}; end
          PH_PIX_HI: begin hb_n = b; ph_n = PH_PIX_LO; end
          PH_PIX_LO: begin ph_n = PH_PIX_HI; emit_px = 1'b1; px_v = {high_byte, b}; end
          default: ;
        endcase
      end
      // ASCII value above 16 bits: v<<16 / maxval saturates anyway
      if (emit_px && phase == PH_PIX_ASCII && num[16]) px_v = 16'hFFFF;
      // end of file completes a pending ASCII value
      if (item.end_of_file && !(emit_rs && rk == KIND_ERROR)) begin
        if (ph_n == PH_PIX_ASCII && ds_n && !ic_n && !emit_px) begin
          emit_px = 1'b1; px_v = acc_n[16] ? 16'hFFFF : acc_n[15:0];
          acc_n = '0; ds_n = 1'b0;
        end
      end
      if (emit_px) begin
        pd_n = pixels_done + 25'd1;
        if (col_count + 13'd1 >= width_reg) begin c_n = '0; r_n = row_count + 13'd1; end
        else c_n = col_count + 13'd1;
        if (26'(pd_n) >= total) begin last_n = 1'b1; ph_n = PH_DONE; end
      end
      if (item.end_of_file && !(emit_rs && rk == KIND_ERROR) && ph_n != PH_DONE) begin
        emit_px = 1'b0; emit_rs = 1'b1; rk = KIND_ERROR;
        ec = (ph_n <= PH_MAGIC_D) ? ERR_MAGIC : ERR_FIELD;
      end
      if (emit_rs && rk == KIND_ERROR) hl_n = 1'b1;
    end
  end

  always_comb begin
    pend_n = '0;
    pend_n.result_kind = emit_px ? KIND_PIXEL : rk;
    pend_n.error_code = ec;
    pend_n.last_pixel = last_n;
    if (!emit_px && rk == KIND_HEADER) begin
      pend_n.image_width = w_n; pend_n.image_height = h_n;
    end
  end

  assign trial_rem = {rem_r[15:0], 1'b0};
  assign trial = {1'b0, trial_rem} - {2'b0, maxval_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC_P; magic_char <= '0; high_byte <= '0; in_comment <= 1'b0;
      digits_seen <= 1'b0; halted <= 1'b0;
      acc <= '0; width_reg <= '0; height_reg <= '0; row_count <= '0;
      col_count <= '0; maxval_reg <= '0; pixels_done <= '0; div_cnt <= '0;
    end else begin
      if (cmd.parse) begin
        phase <= ph_n; magic_char <= mc_n; high_byte <= hb_n; in_comment <= ic_n;
        digits_seen <= ds_n; halted <= hl_n;
        acc <= acc_n; width_reg <= w_n; height_reg <= h_n; row_count <= r_n;
        col_count <= c_n; maxval_reg <= mv_n; pixels_done <= pd_n;
      end
      if (cmd.div_start) div_cnt <= 5'd16;
      else if (cmd.div_step && div_cnt != 5'd0) div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.parse) begin
      pend <= pend_n;
      pix_raw <= px_v; prow <= row_count; pcol <= col_count;
    end
    if (cmd.mul_go) begin
      if (row_first) idx_r <= 24'(26'(prow) * 26'(width_reg) + 26'(pcol));
      else idx_r <= 24'(26'(pcol) * 26'(height_reg) + 26'(prow));
    end
    if (cmd.div_start) begin
      rem_r <= {1'b0, pix_raw}; quo <= '0; sat <= (pix_raw >= maxval_reg);
    end else if (cmd.div_step && div_cnt != 5'd0) begin
      if (!trial[17]) begin rem_r <= trial[16:0]; quo <= {quo[14:0], 1'b1}; end
      else begin rem_r <= trial_rem; quo <= {quo[14:0], 1'b0}; end
    end
  end

  always_comb begin
    res = pend;
    if (pend.result_kind == KIND_PIXEL) begin
      res.pixel_value = sat ? 17'd65536 : {1'b0, quo};
      res.dest_index = idx_r;
    end
  end

  assign stat.want_pixel = emit_px;
  assign stat.want_result = emit_rs;
  assign stat.div_done = (div_cnt == 5'd1);
  assign stat.halted = halted || phase == PH_DONE;

endmodule
